/* hdl/mono_framebuffer_bitmap_blitter_defines.svh */
// Assertion macros for the framebuffer blitter.
`ifndef MONO_FRAMEBUFFER_BITMAP_BLITTER_DEFINES_SVH
`define MONO_FRAMEBUFFER_BITMAP_BLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MFBB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfbb: implication check failed");
`define MFBB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfbb: next-cycle check failed");
`else
`define MFBB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MFBB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hdl/mfbb_pkg.sv */
package mfbb_pkg;

   localparam int NUM_LANES    = 8;
   localparam int LANE_W       = 3;
   localparam int PIXEL_W      = 8;
   localparam int COORD_W      = 11;
   localparam int XY_W         = 10;
   localparam int ORIGIN_W     = 9;
   localparam int DIM_W        = 8;
   localparam int COLB_W       = 5;
   localparam int BYTE_INDEX_W = 10;
   localparam int CSR_AW       = 4;
   localparam int CSR_DW       = 32;

   localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
   localparam logic [1:0] REG_BITMAP_WIDTH  = 2'd2;
   localparam logic [1:0] REG_BITMAP_HEIGHT = 2'd3;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_PLOT  = 2'd1,
      MODE_BLIT  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [PIXEL_W-1:0]        pixel_byte_type;

   typedef struct packed {
      mode_type               mode;
      coord_type              base_x;
      coord_type              base_y;
      logic [NUM_LANES-1:0]   lane_en;
      logic                   idx_ok;
      logic [LANE_W-1:0]      idx_bank;
   } item_type;

endpackage

/* hdl/mfbb_bank.sv */
module mfbb_bank #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  mfbb_pkg::pixel_byte_type wdata,
   input  logic [AW-1:0]           raddr,
   output mfbb_pkg::pixel_byte_type rdata
);
   import mfbb_pkg::*;

   pixel_byte_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hdl/mfbb_lane.sv */
module mfbb_lane #(
   parameter int SCREEN_WIDTH = 128,
   parameter int LA_W         = 10,
   parameter int LANE         = 0
) (
   input  logic                 en_in,
   input  mfbb_pkg::coord_type  base_x,
   input  logic [LA_W-1:0]      row_base,
   output logic                 en_out,
   output logic [LA_W-1:0]      addr
);
   import mfbb_pkg::*;

   coord_type x;

   always_comb begin
      x      = base_x + COORD_W'(LANE);
      en_out = en_in && !x[COORD_W-1] && (x < $signed(COORD_W'(SCREEN_WIDTH)));
      addr   = LA_W'($unsigned(x)) + row_base;
   end

endmodule

/* hdl/mfbb_merge.sv */
module mfbb_merge #(
   parameter int LA_W = 10
) (
   input  logic [mfbb_pkg::NUM_LANES-1:0] lane_en,
   input  logic [LA_W-1:0]                lane_addr [mfbb_pkg::NUM_LANES],
   output logic [mfbb_pkg::NUM_LANES-1:0] bank_en,
   output logic [LA_W-mfbb_pkg::LANE_W-1:0] bank_row [mfbb_pkg::NUM_LANES]
);
   import mfbb_pkg::*;

   // lanes hold consecutive addresses, so bank k takes lane (k - base) mod 8
   always_comb begin
      logic [LANE_W-1:0] sel;
      sel = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         sel         = LANE_W'(k) - lane_addr[0][LANE_W-1:0];
         bank_en[k]  = lane_en[sel];
         bank_row[k] = lane_addr[sel][LA_W-1:LANE_W];
      end
   end

endmodule

/* hdl/mono_framebuffer_bitmap_blitter.sv */
// A read transaction strobes rsp_valid for one cycle, in ST_WRITE, which follows ST_READ after start is taken.
// Plot and bitmap-byte transactions do one bank read, then the OR write-back; a read transaction
// reads the banks, then returns the byte in ST_WRITE; busy drops in ST_WRITE so the next one overlaps it.
// Clear: busy until every bank row is zeroed, one row of all eight banks per cycle.
// Reset: synchronous; the same clearing pass runs, origin returns to 0,0 and bitmap to 8x8.
// Results are not held: rsp_valid and rsp_read_byte last exactly one cycle.
`include "mono_framebuffer_bitmap_blitter_defines.svh"

module mono_framebuffer_bitmap_blitter #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mfbb_pkg::mode_type                   req_mode,
   input  logic signed [mfbb_pkg::XY_W-1:0]     req_pixel_x,
   input  logic signed [mfbb_pkg::XY_W-1:0]     req_pixel_y,
   input  logic [mfbb_pkg::PIXEL_W-1:0]         req_bitmap_byte,
   input  logic [mfbb_pkg::BYTE_INDEX_W-1:0]    req_byte_index,
   output logic                                 rsp_valid,
   output logic [mfbb_pkg::PIXEL_W-1:0]         rsp_read_byte,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mfbb_pkg::CSR_AW-1:0]          paddr,
   input  logic [mfbb_pkg::CSR_DW-1:0]          pwdata,
   output logic [mfbb_pkg::CSR_DW-1:0]          prdata,
   output logic                                 pready
);
   import mfbb_pkg::*;

   localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
   localparam int BANK_DEPTH  = (STORE_BYTES + NUM_LANES - 1) / NUM_LANES;
   localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int LA_W        = BANK_AW + LANE_W;
   localparam int EXT_W       = ((LA_W > BYTE_INDEX_W) ? LA_W : BYTE_INDEX_W) + 1;

   state_type state_ff, state_in;

   logic signed [ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic signed [ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [DIM_W-1:0]           bitmap_width_ff, bitmap_width_in;
   logic [DIM_W-1:0]           bitmap_height_ff, bitmap_height_in;
   logic [COLB_W-1:0]          col_ff, col_in;
   logic [DIM_W-1:0]           row_ff, row_in;

   item_type           item_ff, item_in;
   logic [BANK_AW-1:0] idx_row_ff, idx_row_in;
   logic [BANK_AW-1:0] clr_cnt_ff;

   logic [NUM_LANES-1:0] bank_en_ff;
   logic [BANK_AW-1:0]   bank_row_ff [NUM_LANES];
   pixel_byte_type       bit_ff;

   logic                 cfg_we;
   logic [1:0]           cfg_idx;
   logic                 accept;
   logic [DIM_W:0]       bw_sum;
   logic [COLB_W:0]      bw_eff;
   logic                 col_last;
   logic                 row_last;
   logic                 row_active;
   logic [DIM_W-1:0]     lane_col;
   logic [EXT_W-1:0]     idx_ext;

   logic                 y_ok;
   logic [LA_W-1:0]      row_base;
   logic [NUM_LANES-1:0] lane_en_in;
   logic [NUM_LANES-1:0] lane_en_out;
   logic [LA_W-1:0]      lane_addr [NUM_LANES];
   logic [NUM_LANES-1:0] merge_en;
   logic [BANK_AW-1:0]   merge_row [NUM_LANES];

   logic [NUM_LANES-1:0] bank_we;
   logic [BANK_AW-1:0]   bank_waddr [NUM_LANES];
   pixel_byte_type       bank_wdata [NUM_LANES];
   logic [BANK_AW-1:0]   bank_raddr [NUM_LANES];
   pixel_byte_type       bank_rdata [NUM_LANES];

   // configuration port
   assign pready  = 1'b1;
   assign cfg_we  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[CSR_AW-1:2];

   always_comb begin
      unique case (cfg_idx)
         REG_ORIGIN_X:      prdata = CSR_DW'(origin_x_ff);
         REG_ORIGIN_Y:      prdata = CSR_DW'(origin_y_ff);
         REG_BITMAP_WIDTH:  prdata = CSR_DW'(bitmap_width_ff);
         REG_BITMAP_HEIGHT: prdata = CSR_DW'(bitmap_height_ff);
         default:           prdata = '0;
      endcase
   end

   // transaction intake
   assign busy   = !((state_ff == ST_IDLE) || (state_ff == ST_WRITE));
   assign accept = start & !busy;

   always_comb begin
      bw_sum     = {1'b0, bitmap_width_ff} + (DIM_W + 1)'(7);
      bw_eff     = (bw_sum[DIM_W:3] == '0) ? (COLB_W + 1)'(1) : bw_sum[DIM_W:3];
      col_last   = ({1'b0, col_ff} + (COLB_W + 1)'(1)) >= bw_eff;
      row_last   = ({1'b0, row_ff} + (DIM_W + 1)'(1)) >= {1'b0, bitmap_height_ff};
      row_active = row_ff < bitmap_height_ff;
      idx_ext    = EXT_W'(req_byte_index);
      lane_col   = '0;

      item_in          = item_ff;
      idx_row_in       = idx_row_ff;
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      bitmap_width_in  = bitmap_width_ff;
      bitmap_height_in = bitmap_height_ff;
      col_in           = col_ff;
      row_in           = row_ff;

      if (accept) begin
         item_in.mode     = req_mode;
         item_in.base_x   = COORD_W'(req_pixel_x);
         item_in.base_y   = COORD_W'(req_pixel_y);
         item_in.lane_en  = '0;
         item_in.idx_ok   = idx_ext < EXT_W'(STORE_BYTES);
         item_in.idx_bank = req_byte_index[LANE_W-1:0];
         idx_row_in       = idx_ext[LA_W-1:LANE_W];
         case (req_mode)
            MODE_PLOT: begin
               item_in.lane_en = NUM_LANES'(1);
            end
            MODE_BLIT: begin
               item_in.base_x = COORD_W'(origin_x_ff) + COORD_W'({col_ff, 3'b000});
               item_in.base_y = COORD_W'(origin_y_ff) + COORD_W'(row_ff);
               for (int b = 0; b < NUM_LANES; b++) begin
                  lane_col           = {col_ff, LANE_W'(b)};
                  item_in.lane_en[b] = row_active && (lane_col < bitmap_width_ff) &&
                                       req_bitmap_byte[NUM_LANES - 1 - b];
               end
               if (col_last) begin
                  col_in = '0;
                  row_in = row_last ? '0 : row_ff + DIM_W'(1);
               end else begin
                  col_in = col_ff + COLB_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (cfg_we) begin
         unique case (cfg_idx)
            REG_ORIGIN_X: origin_x_in = pwdata[ORIGIN_W-1:0];
            REG_ORIGIN_Y: origin_y_in = pwdata[ORIGIN_W-1:0];
            REG_BITMAP_WIDTH: begin
               bitmap_width_in = pwdata[DIM_W-1:0];
               col_in          = '0;
               row_in          = '0;
            end
            REG_BITMAP_HEIGHT: begin
               bitmap_height_in = pwdata[DIM_W-1:0];
               col_in           = '0;
               row_in           = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_CLEAR: begin
            if (clr_cnt_ff == BANK_AW'(BANK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_WRITE;
         ST_IDLE, ST_WRITE: begin
            if (accept) begin
               state_in = (req_mode == MODE_CLEAR) ? ST_CLEAR : ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         bitmap_width_ff  <= DIM_W'(8);
         bitmap_height_ff <= DIM_W'(8);
         col_ff           <= '0;
         row_ff           <= '0;
         clr_cnt_ff       <= '0;
      end else begin
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         bitmap_width_ff  <= bitmap_width_in;
         bitmap_height_ff <= bitmap_height_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         clr_cnt_ff       <= (state_ff == ST_CLEAR) ? clr_cnt_ff + BANK_AW'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      idx_row_ff <= idx_row_in;
   end

   // pixel lanes
   always_comb begin
      y_ok       = !item_ff.base_y[COORD_W-1] &&
                   (item_ff.base_y < $signed(COORD_W'(SCREEN_HEIGHT)));
      row_base   = LA_W'(item_ff.base_y[6:3]) * LA_W'(SCREEN_WIDTH);
      lane_en_in = item_ff.lane_en & {NUM_LANES{y_ok}};
   end

   for (genvar b = 0; b < NUM_LANES; b++) begin : g_lane
      mfbb_lane #(
         .SCREEN_WIDTH (SCREEN_WIDTH),
         .LA_W         (LA_W),
         .LANE         (b)
      ) u_lane (
         .en_in    (lane_en_in[b]),
         .base_x   (item_ff.base_x),
         .row_base (row_base),
         .en_out   (lane_en_out[b]),
         .addr     (lane_addr[b])
      );
   end

   mfbb_merge #(
      .LA_W (LA_W)
   ) u_merge (
      .lane_en   (lane_en_out),
      .lane_addr (lane_addr),
      .bank_en   (merge_en),
      .bank_row  (merge_row)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         bank_en_ff  <= merge_en;
         bank_row_ff <= merge_row;
         bit_ff      <= PIXEL_W'(1) << item_ff.base_y[2:0];
      end
   end

   // banks, interleaved on the low three address bits
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_bank
      always_comb begin
         bank_raddr[k] = (item_ff.mode == MODE_READ) ? idx_row_ff : merge_row[k];
         if (state_ff == ST_CLEAR) begin
            bank_we[k]    = 1'b1;
            bank_waddr[k] = clr_cnt_ff;
            bank_wdata[k] = '0;
         end else begin
            bank_we[k]    = (state_ff == ST_WRITE) && bank_en_ff[k];
            bank_waddr[k] = bank_row_ff[k];
            bank_wdata[k] = bank_rdata[k] | bit_ff;
         end
      end

      mfbb_bank #(
         .DEPTH (BANK_DEPTH),
         .AW    (BANK_AW)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[k]),
         .waddr (bank_waddr[k]),
         .wdata (bank_wdata[k]),
         .raddr (bank_raddr[k]),
         .rdata (bank_rdata[k])
      );
   end

   // result
   assign rsp_valid     = (state_ff == ST_WRITE) && (item_ff.mode == MODE_READ);
   assign rsp_read_byte = item_ff.idx_ok ? bank_rdata[item_ff.idx_bank] : '0;

   `MFBB_ASSERT_IMP(a_rsp_follows_read, clock, reset, rsp_valid, $past(state_ff == ST_READ))
   `MFBB_ASSERT_IMP(a_no_write_on_rsp, clock, reset, rsp_valid, bank_we == '0)
   `MFBB_ASSERT_NXT(a_clear_entered, clock, reset, accept && (req_mode == MODE_CLEAR), state_ff == ST_CLEAR && busy)
   `MFBB_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, busy)

endmodule

/* dv/tb_mono_framebuffer_bitmap_blitter.sv */
`timescale 1ns / 100ps

module tb_mono_framebuffer_bitmap_blitter;
   import mfbb_pkg::*;

   localparam int SCR_W         = 128;
   localparam int SCR_H         = 64;
   localparam int FB_BYTES      = SCR_W * ((SCR_H + 7) / 8);
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_PHASES    = 14;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      mode_type                  mode;
      logic signed [XY_W-1:0]    px;
      logic signed [XY_W-1:0]    py;
      logic [PIXEL_W-1:0]        bbyte;
      logic [BYTE_INDEX_W-1:0]   idx;
   } blit_op_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   mode_type                      req_mode = MODE_CLEAR;
   logic signed [XY_W-1:0]        req_pixel_x = '0;
   logic signed [XY_W-1:0]        req_pixel_y = '0;
   logic [PIXEL_W-1:0]            req_bitmap_byte = '0;
   logic [BYTE_INDEX_W-1:0]       req_byte_index = '0;
   logic                          rsp_valid;
   logic [PIXEL_W-1:0]            rsp_read_byte;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_AW-1:0]             paddr = '0;
   logic [CSR_DW-1:0]             pwdata = '0;
   logic [CSR_DW-1:0]             prdata;
   logic                          pready;

   // frame store model and blitter state
   logic [7:0]     fb_model [0:FB_BYTES-1];
   int             org_x = 0;
   int             org_y = 0;
   int             bm_width = 8;
   int             bm_height = 8;
   int             col_byte = 0;
   int             bm_row = 0;

   blit_op_type    pending_ops[$];
   blit_op_type    cur_op;
   logic [7:0]     read_bytes_due[$];
   logic [7:0]     want_byte;
   int             idle_pct = 21;
   int             n_mismatch = 0;
   int             cycle_count = 0;

   mono_framebuffer_bitmap_blitter #(
      .SCREEN_WIDTH  (SCR_W),
      .SCREEN_HEIGHT (SCR_H)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_bitmap_byte (req_bitmap_byte),
      .req_byte_index  (req_byte_index),
      .rsp_valid       (rsp_valid),
      .rsp_read_byte   (rsp_read_byte),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void plot_pixel(int x, int y);
      if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) begin
         fb_model[x + (y / 8) * SCR_W][y % 8] = 1'b1;
      end
   endfunction

   function automatic void blit_byte(logic [7:0] bits);
      int bytes_per_row;
      int col;
      bytes_per_row = (bm_width + 7) >> 3;
      if (bytes_per_row == 0) begin
         bytes_per_row = 1;
      end
      if (bm_row < bm_height) begin
         for (int b = 0; b < 8; b++) begin
            col = col_byte * 8 + b;
            if (col < bm_width && bits[7-b]) begin
               plot_pixel(org_x + col, org_y + bm_row);
            end
         end
      end
      if (col_byte + 1 >= bytes_per_row) begin
         col_byte = 0;
         if (bm_row + 1 >= bm_height) begin
            bm_row = 0;
         end else begin
            bm_row = (bm_row + 1) & 8'hFF;
         end
      end else begin
         col_byte = (col_byte + 1) & 5'h1F;
      end
   endfunction

   function automatic void apply_op(blit_op_type op);
      case (op.mode)
         MODE_CLEAR: begin
            foreach (fb_model[i]) fb_model[i] = '0;
         end
         MODE_PLOT: begin
            plot_pixel(int'(op.px), int'(op.py));
         end
         MODE_BLIT: begin
            blit_byte(op.bbyte);
         end
         default: begin
            read_bytes_due.push_back(op.idx < FB_BYTES ? fb_model[op.idx] : 8'h00);
         end
      endcase
   endfunction

   function automatic void push_op(mode_type m, int x, int y, int bb, int ix);
      blit_op_type op;
      op.mode  = m;
      op.px    = x[XY_W-1:0];
      op.py    = y[XY_W-1:0];
      op.bbyte = bb[PIXEL_W-1:0];
      op.idx   = ix[BYTE_INDEX_W-1:0];
      pending_ops.push_back(op);
   endfunction

   function automatic void push_random_op();
      int pick;
      int x;
      int y;
      pick = $urandom_range(0, 99);
      x = $urandom;
      y = $urandom;
      if ($urandom_range(0, 9) < 7) begin
         x = int'($urandom_range(0, SCR_W + 15)) - 8;
         y = int'($urandom_range(0, SCR_H + 15)) - 8;
      end
      if (pick < 2) begin
         push_op(MODE_CLEAR, x, y, $urandom, $urandom);
      end else if (pick < 32) begin
         push_op(MODE_PLOT, x, y, $urandom, $urandom);
      end else if (pick < 78) begin
         push_op(MODE_BLIT, x, y, $urandom, $urandom);
      end else begin
         push_op(MODE_READ, x, y, $urandom, $urandom);
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_op(cur_op);
         end
         if (!start || !busy) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               cur_op = pending_ops.pop_front();
               start           <= 1'b1;
               req_mode        <= cur_op.mode;
               req_pixel_x     <= cur_op.px;
               req_pixel_y     <= cur_op.py;
               req_bitmap_byte <= cur_op.bbyte;
               req_byte_index  <= cur_op.idx;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (read_bytes_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
               $display("unexpected read transaction, read_byte %02h", rsp_read_byte);
            end
         end else begin
            want_byte = read_bytes_due.pop_front();
            if (rsp_read_byte !== want_byte) begin
               n_mismatch++;
               if (n_mismatch <= MAX_REPORTS) begin
                  $display("read_byte: expected %02h, got %02h", want_byte, rsp_read_byte);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mono_framebuffer_bitmap_blitter: mismatch");
         $finish;
      end
   end

   task automatic wait_drained();
      int quiet;
      quiet = 0;
      while (quiet < SETTLE_CYCLES) begin
         @(negedge clock);
         if (pending_ops.size() == 0 && !start && !busy && read_bytes_due.size() == 0) begin
            quiet++;
         end else begin
            quiet = 0;
         end
      end
   endtask

   task automatic csr_write(logic [1:0] reg_idx, logic [31:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (reg_idx)
         REG_ORIGIN_X: org_x = int'($signed(val[ORIGIN_W-1:0]));
         REG_ORIGIN_Y: org_y = int'($signed(val[ORIGIN_W-1:0]));
         REG_BITMAP_WIDTH: begin
            bm_width = int'(val[DIM_W-1:0]);
            col_byte = 0;
            bm_row   = 0;
         end
         default: begin
            bm_height = int'(val[DIM_W-1:0]);
            col_byte  = 0;
            bm_row    = 0;
         end
      endcase
   endtask

   task automatic set_geometry(int ox, int oy, int w, int h);
      csr_write(REG_ORIGIN_X, 32'(ox));
      csr_write(REG_ORIGIN_Y, 32'(oy));
      csr_write(REG_BITMAP_WIDTH, 32'(w));
      csr_write(REG_BITMAP_HEIGHT, 32'(h));
   endtask

   initial begin
      int n_ops;
      foreach (fb_model[i]) fb_model[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners, off-screen edges, default 8x8 bitmap, clear
      push_op(MODE_READ, 0, 0, 0, 0);
      push_op(MODE_PLOT, 0, 0, 0, 0);
      push_op(MODE_PLOT, SCR_W - 1, SCR_H - 1, 0, 0);
      push_op(MODE_PLOT, -1, 0, 0, 0);
      push_op(MODE_PLOT, SCR_W, 5, 0, 0);
      push_op(MODE_PLOT, 5, -1, 0, 0);
      push_op(MODE_PLOT, 5, SCR_H, 0, 0);
      push_op(MODE_PLOT, -512, -512, 8'hFF, 10'h3FF);
      push_op(MODE_PLOT, 511, 511, 8'hFF, 10'h3FF);
      push_op(MODE_READ, 0, 0, 0, 0);
      push_op(MODE_READ, 0, 0, 0, FB_BYTES - 1);
      push_op(MODE_BLIT, 0, 0, 8'hFF, 0);
      push_op(MODE_BLIT, 0, 0, 8'h00, 0);
      push_op(MODE_BLIT, 0, 0, 8'hA5, 0);
      push_op(MODE_READ, 0, 0, 0, 0);
      push_op(MODE_READ, 0, 0, 0, 5);
      push_op(MODE_READ, 0, 0, 0, 7);
      push_op(MODE_CLEAR, 0, 0, 0, 0);
      push_op(MODE_READ, 0, 0, 0, 0);
      push_op(MODE_READ, 0, 0, 0, FB_BYTES - 1);
      push_op(MODE_BLIT, 0, 0, 8'h81, 0);
      push_op(MODE_READ, 0, 0, 0, 7);
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 7)
            0: set_geometry(int'($urandom_range(0, 130)) - 30,
                            int'($urandom_range(0, 70)) - 20,
                            $urandom_range(1, 255), $urandom_range(1, 255));
            1: set_geometry(-256, 255, 255, 1);
            2: set_geometry(3, -5, 0, 9);
            3: set_geometry(-4, 10, 20, 0);
            4: begin
               // origin only: counters carry on
               csr_write(REG_ORIGIN_X, 32'(int'($urandom_range(0, 140)) - 20));
               csr_write(REG_ORIGIN_Y, 32'(int'($urandom_range(0, 80)) - 20));
            end
            5: set_geometry(255, -256, 1, 255);
            default: set_geometry(int'($urandom_range(0, 70)) - 10,
                                  int'($urandom_range(0, 50)) - 10,
                                  $urandom_range(1, 40), $urandom_range(1, 24));
         endcase
         idle_pct = (phase == 6) ? 0 : 21;
         @(negedge clock);
         n_ops = $urandom_range(85, 120);
         repeat (n_ops) push_random_op();
         wait_drained();
      end

      if (n_mismatch == 0 && read_bytes_due.size() == 0) begin
         $display("mono_framebuffer_bitmap_blitter: match");
      end else begin
         $display("mono_framebuffer_bitmap_blitter: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mfbb_pkg.sv
hdl/mfbb_bank.sv
hdl/mfbb_lane.sv
hdl/mfbb_merge.sv
hdl/mono_framebuffer_bitmap_blitter.sv
dv/tb_mono_framebuffer_bitmap_blitter.sv
